// ----- design/pbe_pkg.sv -----
// ----------------------------------------------------------------------------
// pbe_pkg
// Shared constants, codes and field widths of the piecewise bin encoder.
// ----------------------------------------------------------------------------
package pbe_pkg;

    localparam int NUM_FEATURES = 16;
    localparam int BIN_SLOTS    = 16;
    localparam int TABLE_DEPTH  = NUM_FEATURES * BIN_SLOTS;
    localparam int ADDR_W       = $clog2(TABLE_DEPTH);
    localparam int NB_W         = $clog2(BIN_SLOTS + 1);

    // Fixed field widths of the stream items
    localparam int MODE_W = 2;
    localparam int FEAT_W = 4;
    localparam int BIN_W  = 4;
    localparam int VAL_W  = 32;
    localparam int CNT_W  = 5;
    localparam int FRAC_W = 16;

    // Input tdata layout, lowest bit first
    localparam int IN_FEAT_LSB   = 0;
    localparam int IN_BIN_LSB    = IN_FEAT_LSB + FEAT_W;
    localparam int IN_W_LSB      = IN_BIN_LSB + BIN_W;
    localparam int IN_B_LSB      = IN_W_LSB + VAL_W;
    localparam int IN_CNT_LSB    = IN_B_LSB + VAL_W;
    localparam int IN_X_LSB      = IN_CNT_LSB + CNT_W;
    localparam int IN_USED_W     = IN_X_LSB + VAL_W;
    localparam int IN_TDATA_W    = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W   = (((VAL_W + FEAT_W + BIN_W) + 7) / 8) * 8;

    // Output queue
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CRED_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [VAL_W-1:0] Q_ONE  = VAL_W'(1 << FRAC_W);
    localparam logic signed [VAL_W-1:0] Q_ZERO = '0;

    typedef enum logic [MODE_W-1:0] {
        MODE_WRITE_ENTRY = 2'd0,
        MODE_WRITE_BINS  = 2'd1,
        MODE_ENCODE      = 2'd2
    } t_mode;

    typedef struct packed {
        logic [FEAT_W-1:0] feat;
        logic [BIN_W-1:0]  bin;
        logic              first;
        logic              last;
        logic              single;
        logic [VAL_W-1:0]  x;
    } t_meta;

endpackage

// ----- design/pbe_ram.sv -----
// ----------------------------------------------------------------------------
// pbe_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module pbe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/piecewise_bin_encoder.sv -----
// ----------------------------------------------------------------------------
// piecewise_bin_encoder
// Piecewise linear encoding of scalar features in signed Q16.16.
// ----------------------------------------------------------------------------
// A request on the input stream either loads a weight/bias pair of one
// (feature, bin) entry (tuser = write entry), loads the bin count of a
// feature (tuser = write bins), or encodes one sample of a feature
// (tuser = encode). Loads give no result. An encode request of a feature
// with N bins emits N results in bin order, tlast on the final one; a
// feature with no bins emits nothing. Each result is bias + floor(weight *
// x / 2^16), saturated to 32 bits, then the first bin is capped at 1.0, the
// last floored at 0 and middle bins clamped to [0, 1.0]; a single-bin
// feature gives 1.0 when x >= bias, else 0. Rate: an encode request holds
// the input until its last bin is read, one bin per cycle while the output
// queue has credit, set by the single read port of the weight/bias RAM
// which is read once per bin; with the output ready results stream out one
// per cycle via the RAM data and product registers and the output queue.
// The next request is taken once the last bin is read, while results still
// drain through the four-entry output queue. No clearing pass is needed
// after reset: the bin counts live in flip-flops and reset to zero.
// ----------------------------------------------------------------------------
module piecewise_bin_encoder
    import pbe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // tdata: feature_index, bin_index, weight_value, bias_value, bin_count,
    //        sample_value, zero pad
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // tuser: mode
    input  logic [MODE_W-1:0]      i_s_axis_tuser,
    // Output stream
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // tdata: encoded_value, out_feature, out_bin
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // tlast: last_of_run
    output logic                   o_m_axis_tlast
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    // ------------------------------------------------------------------------
    // Field unpacking
    // ------------------------------------------------------------------------
    logic [FEAT_W-1:0] in_feat;
    logic [BIN_W-1:0]  in_bin;
    logic [VAL_W-1:0]  in_weight;
    logic [VAL_W-1:0]  in_bias;
    logic [CNT_W-1:0]  in_cnt;
    logic [VAL_W-1:0]  in_x;
    t_mode             in_mode;

    assign in_feat   = i_s_axis_tdata[IN_FEAT_LSB +: FEAT_W];
    assign in_bin    = i_s_axis_tdata[IN_BIN_LSB  +: BIN_W];
    assign in_weight = i_s_axis_tdata[IN_W_LSB    +: VAL_W];
    assign in_bias   = i_s_axis_tdata[IN_B_LSB    +: VAL_W];
    assign in_cnt    = i_s_axis_tdata[IN_CNT_LSB  +: CNT_W];
    assign in_x      = i_s_axis_tdata[IN_X_LSB    +: VAL_W];
    assign in_mode   = t_mode'(i_s_axis_tuser);

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    t_state                r_state, n_state;
    logic [NB_W-1:0]       r_bins [NUM_FEATURES];
    logic [FEAT_W-1:0]     r_feat, n_feat;
    logic [NB_W-1:0]       r_nb, n_nb;
    logic [NB_W-1:0]       r_bin, n_bin;
    logic [VAL_W-1:0]      r_x, n_x;
    logic [CRED_W-1:0]     r_credit, n_credit;

    // read pipeline: stage 1 holds RAM data, stage 2 the product
    logic                  r_s1_vld;
    t_meta                 r_s1_meta;
    logic                  r_s2_vld;
    t_meta                 r_s2_meta;
    logic signed [2*VAL_W-1:0] r_s2_prod;
    logic signed [VAL_W-1:0]   r_s2_bias;

    // output queue
    logic [VAL_W+FEAT_W+BIN_W:0] r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]      r_wptr, r_rptr;
    logic [CRED_W-1:0]     r_fcnt;

    // ------------------------------------------------------------------------
    // Handshakes
    // ------------------------------------------------------------------------
    logic acc_in, pop, issue, feat_ok;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign acc_in  = i_s_axis_tvalid && o_s_axis_tready;
    assign pop     = o_m_axis_tvalid && i_m_axis_tready;
    assign feat_ok = (32'(in_feat) < NUM_FEATURES);
    // a slot freed this cycle may be reused at once
    assign issue   = (r_state == S_RUN)
                  && ((r_credit < CRED_W'(FIFO_DEPTH)) || pop);

    // ------------------------------------------------------------------------
    // Weight/bias table: {bias, weight} per entry
    // ------------------------------------------------------------------------
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [2*VAL_W-1:0] ram_rdata;

    assign ram_we    = acc_in && (in_mode == MODE_WRITE_ENTRY) && feat_ok
                    && (32'(in_bin) < BIN_SLOTS);
    assign ram_waddr = ADDR_W'(32'(in_feat) * BIN_SLOTS + 32'(in_bin));
    assign ram_raddr = ADDR_W'(32'(r_feat) * BIN_SLOTS + 32'(r_bin));

    pbe_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({in_bias, in_weight}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------------
    // Sequencer: accept, then walk the bins of the feature
    // ------------------------------------------------------------------------
    logic [NB_W-1:0] lookup_nb;
    logic [NB_W-1:0] sat_cnt;
    logic            issue_last;
    t_meta           issue_meta;

    assign lookup_nb  = r_bins[in_feat];
    assign sat_cnt    = (32'(in_cnt) > BIN_SLOTS) ? NB_W'(BIN_SLOTS) : NB_W'(in_cnt);
    assign issue_last = (r_bin == r_nb - NB_W'(1));

    always_comb begin
        issue_meta.feat   = r_feat;
        issue_meta.bin    = BIN_W'(r_bin);
        issue_meta.first  = (r_bin == '0);
        issue_meta.last   = issue_last;
        issue_meta.single = (r_nb == NB_W'(1));
        issue_meta.x      = r_x;
    end

    always_comb begin
        n_state  = r_state;
        n_feat   = r_feat;
        n_nb     = r_nb;
        n_bin    = r_bin;
        n_x      = r_x;
        n_credit = r_credit + CRED_W'(issue) - CRED_W'(pop);
        unique case (r_state)
            S_IDLE: begin
                if (acc_in && (in_mode == MODE_ENCODE) && feat_ok
                    && (lookup_nb != '0)) begin
                    n_state = S_RUN;
                    n_feat  = in_feat;
                    n_nb    = lookup_nb;
                    n_bin   = '0;
                    n_x     = in_x;
                end
            end
            S_RUN: begin
                if (issue) begin
                    n_bin = r_bin + NB_W'(1);
                    if (issue_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Stage 3: floor shift, saturating add, clamp
    // ------------------------------------------------------------------------
    localparam int SUM_W = 2 * VAL_W - FRAC_W + 1;

    logic signed [SUM_W-1:0] sum;
    logic signed [VAL_W-1:0] sat_v, act;

    always_comb begin
        // arithmetic shift of the product is a floor division by 2^16
        sum = SUM_W'(r_s2_bias) + SUM_W'(r_s2_prod >>> FRAC_W);
        if (sum > SUM_W'(signed'({1'b0, {(VAL_W-1){1'b1}}}))) begin
            sat_v = {1'b0, {(VAL_W-1){1'b1}}};
        end else if (sum < SUM_W'(signed'({1'b1, {(VAL_W-1){1'b0}}}))) begin
            sat_v = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            sat_v = sum[VAL_W-1:0];
        end
        act = sat_v;
        if (r_s2_meta.single) begin
            act = ($signed(r_s2_meta.x) >= r_s2_bias) ? Q_ONE : Q_ZERO;
        end else begin
            if (!r_s2_meta.first && (sat_v < Q_ZERO)) begin
                act = Q_ZERO;
            end
            if (!r_s2_meta.last && (sat_v > Q_ONE)) begin
                act = Q_ONE;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Clocked state
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_credit <= '0;
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_fcnt   <= '0;
            for (int f = 0; f < NUM_FEATURES; f++) begin
                r_bins[f] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_credit <= n_credit;
            r_s1_vld <= issue;
            r_s2_vld <= r_s1_vld;
            if (acc_in && (in_mode == MODE_WRITE_BINS) && feat_ok) begin
                r_bins[in_feat] <= sat_cnt;
            end
            if (r_s2_vld) begin
                r_wptr <= r_wptr + PTR_W'(1);
            end
            if (pop) begin
                r_rptr <= r_rptr + PTR_W'(1);
            end
            r_fcnt <= r_fcnt + CRED_W'(r_s2_vld) - CRED_W'(pop);
        end
        // payload, no reset
        r_feat    <= n_feat;
        r_nb      <= n_nb;
        r_bin     <= n_bin;
        r_x       <= n_x;
        r_s1_meta <= issue_meta;
        r_s2_meta <= r_s1_meta;
        r_s2_prod <= $signed(ram_rdata[VAL_W-1:0]) * $signed(r_s1_meta.x);
        r_s2_bias <= $signed(ram_rdata[2*VAL_W-1:VAL_W]);
        if (r_s2_vld) begin
            r_fifo[r_wptr] <= {r_s2_meta.last, r_s2_meta.bin, r_s2_meta.feat, act};
        end
    end

    // ------------------------------------------------------------------------
    // Output
    // ------------------------------------------------------------------------
    assign o_m_axis_tvalid = (r_fcnt != '0);
    assign o_m_axis_tlast  = r_fifo[r_rptr][VAL_W+FEAT_W+BIN_W];
    assign o_m_axis_tdata  = OUT_TDATA_W'(r_fifo[r_rptr][VAL_W+FEAT_W+BIN_W-1:0]);

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CRED_W'(FIFO_DEPTH))
        else $error("outstanding results exceed the output queue");

    a_queue_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fcnt <= r_credit)
        else $error("queued results exceed outstanding credit");

    a_read_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld |-> $past(r_state == S_RUN))
        else $error("table read issued outside a run");

    a_bin_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_bin < r_nb))
        else $error("bin walk ran past the bin count");

endmodule
